@@ src/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// Used by spq_ctrl, spq_datapath and sorted_priority_queue_core.
package spq_pkg;

    localparam int CAPACITY  = 16;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int VAL_W     = 32;
    localparam int OUT_CNT_W = 5;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 40;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_code_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic
    {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed
    {
        logic load;    // capture the input beat
        logic commit;  // apply the op and load the result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed
    {
        logic empty;
        logic full;
    } dp_stat_t;

endpackage

@@ src/sorted_priority_queue_core.sv @@
// Sorted min-priority queue of signed 32-bit values, capacity spq_pkg::CAPACITY.
// An accepted beat is captured in the input hold register and applied in the commit
// state, which loads the result register that drives m_tvalid; one op in flight, so a
// new beat is not accepted until the controller returns from its commit state to idle.
// A result not yet taken holds the controller in its commit state.
// Reset (rst_n low, async): queue empty, no result pending; cell contents undefined.
module sorted_priority_queue_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spq_pkg::S_DATA_W-1:0]  s_tdata,   // [31:0] value
    input  logic [0:0]                    s_tuser,   // [0] cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [spq_pkg::M_DATA_W-1:0]  m_tdata,   // [31:0] out_value, [36:32] count, rest 0
    output logic [1:0]                    m_tuser    // [1:0] status
);

    spq_pkg::dp_cmd_t                  cmd;
    spq_pkg::dp_stat_t                 stat;
    logic signed [spq_pkg::VAL_W-1:0]  out_value;
    spq_pkg::status_t                  out_status;
    logic [spq_pkg::OUT_CNT_W-1:0]     out_count;

    spq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spq_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_cmd     (s_tuser[0]),
        .in_value   (s_tdata[spq_pkg::VAL_W-1:0]),
        .stat       (stat),
        .out_value  (out_value),
        .out_status (out_status),
        .out_count  (out_count)
    );

    assign m_tdata = {{(spq_pkg::M_DATA_W - spq_pkg::VAL_W - spq_pkg::OUT_CNT_W){1'b0}},
                      out_count, out_value};
    assign m_tuser = out_status;

`ifndef NO_ASSERTIONS
    // one op in flight: no beat accepted in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat accepted while op in flight");

    // a commit never overwrites a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("result overwritten");

    // empty remove reports zero entries and zero value
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == spq_pkg::ST_EMPTY) |->
            (m_tdata[spq_pkg::M_DATA_W-1:0] == '0))
        else $error("empty remove with nonzero data");

    // the queue is never both full and empty at a commit
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && stat.full) |-> !stat.empty)
        else $error("queue both full and empty");
`endif

endmodule

@@ src/spq_ctrl.sv @@
// Controller FSM for the sorted priority queue: input handshake, op commit
// and result slot valid. Depends on spq_pkg.
module spq_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  spq_pkg::dp_stat_t stat,
    output spq_pkg::dp_cmd_t  cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            slot_free;

    // result slot can take a new result when empty or being drained
    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (s_tvalid)
                    state_next = spq_pkg::S_EXEC;
            end
            spq_pkg::S_EXEC:
            begin
                if (slot_free)
                    state_next = spq_pkg::S_IDLE;
            end
            default: state_next = spq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            spq_pkg::S_EXEC:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    // full/empty are decided in the datapath; not used by the controller
    logic unused_stat;
    assign unused_stat = stat.empty & stat.full;

endmodule

@@ src/spq_datapath.sv @@
// Datapath for the sorted priority queue: input hold register, sorted cell
// row with per-cell compare, entry count and result register. Depends on spq_pkg.
module spq_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  spq_pkg::dp_cmd_t                  cmd,
    input  logic                              in_cmd,
    input  logic signed [spq_pkg::VAL_W-1:0]  in_value,
    output spq_pkg::dp_stat_t                 stat,
    output logic signed [spq_pkg::VAL_W-1:0]  out_value,
    output spq_pkg::status_t                  out_status,
    output logic [spq_pkg::OUT_CNT_W-1:0]     out_count
);

    logic                             op_reg;
    logic signed [spq_pkg::VAL_W-1:0] val_reg;
    logic [spq_pkg::CNT_W-1:0]        count_reg;
    logic [spq_pkg::CNT_W-1:0]        count_next;
    logic signed [spq_pkg::VAL_W-1:0] cell_reg  [spq_pkg::CAPACITY];
    logic signed [spq_pkg::VAL_W-1:0] cell_next [spq_pkg::CAPACITY];
    logic [spq_pkg::CAPACITY-1:0]     keep;
    logic signed [spq_pkg::VAL_W-1:0] res_value_reg;
    logic signed [spq_pkg::VAL_W-1:0] res_value_next;
    spq_pkg::status_t                 res_status_reg;
    spq_pkg::status_t                 res_status_next;
    logic [spq_pkg::OUT_CNT_W-1:0]    res_count_reg;
    logic                             do_shift_in;
    logic                             do_shift_out;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == spq_pkg::CNT_W'(spq_pkg::CAPACITY));

    // keep[i]: cell holds a stored value <= the new one, so it stays put
    always_comb
    begin
        for (int i = 0; i < spq_pkg::CAPACITY; i++)
            keep[i] = (spq_pkg::CNT_W'(i) < count_reg) && (cell_reg[i] <= val_reg);
    end

    always_comb
    begin
        do_shift_in     = 1'b0;
        do_shift_out    = 1'b0;
        count_next      = count_reg;
        res_value_next  = '0;
        res_status_next = spq_pkg::ST_INSERTED;
        if (op_reg == spq_pkg::CMD_INSERT)
        begin
            if (stat.full)
                res_status_next = spq_pkg::ST_FULL;
            else
            begin
                do_shift_in = 1'b1;
                count_next  = count_reg + 1'b1;
            end
        end
        else
        begin
            if (stat.empty)
                res_status_next = spq_pkg::ST_EMPTY;
            else
            begin
                do_shift_out    = 1'b1;
                res_value_next  = cell_reg[0];
                res_status_next = spq_pkg::ST_REMOVED;
                count_next      = count_reg - 1'b1;
            end
        end
    end

    // each cell picks from itself, its lower neighbor, its upper neighbor or the new value
    always_comb
    begin
        for (int i = 0; i < spq_pkg::CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (do_shift_in && !keep[i])
            begin
                if (i == 0)
                    cell_next[i] = val_reg;
                else if (keep[(i == 0) ? 0 : i - 1])
                    cell_next[i] = val_reg;
                else
                    cell_next[i] = cell_reg[(i == 0) ? 0 : i - 1];
            end
            else if (do_shift_out && (i < spq_pkg::CAPACITY - 1))
                cell_next[i] = cell_reg[(i < spq_pkg::CAPACITY - 1) ? i + 1 : i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.commit)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_cmd;
            val_reg <= in_value;
        end
        if (cmd.commit)
        begin
            for (int i = 0; i < spq_pkg::CAPACITY; i++)
                cell_reg[i] <= cell_next[i];
            res_value_reg  <= res_value_next;
            res_status_reg <= res_status_next;
            res_count_reg  <= spq_pkg::OUT_CNT_W'(count_next);
        end
    end

    assign out_value  = res_value_reg;
    assign out_status = res_status_reg;
    assign out_count  = res_count_reg;

endmodule
